FILE: src/dfs_pkg.sv
// Shared types, constants and helpers of the deadline field selector.
package dfs_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int MAX_REPEATS = 24;
    localparam int DIV_W       = 17;
    localparam int NL_W        = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic signed [18:0] DAY_SD  = 19'sd86400;
    localparam logic signed [18:0] HALF_SD = 19'sd43200;
    localparam logic [17:0]        DAY_U   = 18'd86400;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    localparam logic [8:0]  ACTIVE_RST   = 9'd0;
    localparam logic [7:0]  OVERHEAD_RST = 8'd45;
    localparam logic [15:0] MIN_GAP_RST  = 16'd900;
    localparam logic [11:0] IDLE_RST     = 12'd300;
    localparam logic [NL_W-1:0] NL_INIT  = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE,
        CFG_OVERHEAD,
        CFG_MIN_GAP,
        CFG_IDLE_WAIT
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_P1_START,
        OP_READ,
        OP_P1,
        OP_P2_START,
        OP_P2,
        OP_GO_PICK,
        OP_SH_CHK,
        OP_SH_WR,
        OP_OBS,
        OP_IDLE,
        OP_EMIT
    } t_op;

    typedef struct packed {
        logic take;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic is_load;
        logic empty;
        logic last;
        logic dark;
        logic nready;
        logic pick_v;
        logic sh_ok;
        logic div_done;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  entry_index;
        logic [16:0] clock_now;
        logic        open_shutter;
        logic [16:0] rise_time;
        logic [16:0] set_time;
        logic [16:0] first_time;
        logic [15:0] repeat_gap_s;
        logic [9:0]  exposure_s;
        logic [4:0]  repeats_wanted;
        logic        can_do;
    } t_in;

    typedef struct packed {
        logic        chosen;
        logic [7:0]  chosen_index;
        logic [11:0] duration_s;
        logic [4:0]  repeats_done;
        logic [16:0] next_due;
        logic        was_shortened;
    } t_out;

    typedef struct packed {
        logic [4:0]         done;
        logic [4:0]         wanted;
        logic               shutter;
        logic [16:0]        rise;
        logic [16:0]        set;
        logic [16:0]        due;
        logic [15:0]        gap;
        logic [9:0]         exposure;
        logic signed [17:0] up;
        logic signed [21:0] slack;
    } t_rec;

    // Signed distance from a to b on the day clock, folded into half a day.
    function automatic logic signed [18:0] clk_diff(input logic [16:0] a,
                                                    input logic [16:0] b);
        logic signed [18:0] d;
        d = $signed({2'b00, b}) - $signed({2'b00, a});
        if (d > HALF_SD) d = d - DAY_SD;
        if (d < -HALF_SD) d = d + DAY_SD;
        return d;
    endfunction

    // Seconds from a to b going forward, folded once.
    function automatic logic signed [17:0] fwd_span(input logic [16:0] a,
                                                    input logic [16:0] b);
        logic signed [18:0] d;
        d = $signed({2'b00, b}) - $signed({2'b00, a});
        if (d < 19'sd0) d = d + DAY_SD;
        return d[17:0];
    endfunction

endpackage

FILE: src/dfs_in_if.sv
// Input channel of the deadline field selector.
interface dfs_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  entry_index;
    logic [16:0] clock_now;
    logic        open_shutter;
    logic [16:0] rise_time;
    logic [16:0] set_time;
    logic [16:0] first_time;
    logic [15:0] repeat_gap_s;
    logic [9:0]  exposure_s;
    logic [4:0]  repeats_wanted;
    logic        can_do;

    modport source (output valid, cmd, entry_index, clock_now, open_shutter, rise_time,
                    set_time, first_time, repeat_gap_s, exposure_s, repeats_wanted, can_do,
                    input ready);
    modport sink (input valid, cmd, entry_index, clock_now, open_shutter, rise_time,
                  set_time, first_time, repeat_gap_s, exposure_s, repeats_wanted, can_do,
                  output ready);
endinterface

FILE: src/dfs_out_if.sv
// Result channel of the deadline field selector.
interface dfs_out_if;
    logic        valid;
    logic        ready;
    logic        chosen;
    logic [7:0]  chosen_index;
    logic [11:0] duration_s;
    logic [4:0]  repeats_done;
    logic [16:0] next_due;
    logic        was_shortened;

    modport source (output valid, chosen, chosen_index, duration_s, repeats_done, next_due,
                    was_shortened, input ready);
    modport sink (input valid, chosen, chosen_index, duration_s, repeats_done, next_due,
                  was_shortened, output ready);
endinterface

FILE: src/dfs_div.sv
// Restoring serial divider, one quotient bit per cycle.
module dfs_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [dfs_pkg::DIV_W-1:0]      i_dividend,
    input  logic [dfs_pkg::NL_W-1:0]       i_divisor,
    output logic                           o_done,
    output logic [dfs_pkg::DIV_W-1:0]      o_quot
);
    logic                           r_busy;
    logic                           r_done;
    logic [$clog2(dfs_pkg::DIV_W)-1:0] r_cnt;
    logic [dfs_pkg::NL_W-1:0]       r_rem;
    logic [dfs_pkg::NL_W-1:0]       r_dsr;
    logic [dfs_pkg::DIV_W-1:0]      r_q;
    logic [dfs_pkg::NL_W:0]         rem_sh;
    logic                           ge;

    assign rem_sh = {r_rem, r_q[dfs_pkg::DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= $clog2(dfs_pkg::DIV_W)'(dfs_pkg::DIV_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? dfs_pkg::NL_W'(rem_sh - {1'b0, r_dsr}) : rem_sh[dfs_pkg::NL_W-1:0];
            r_q   <= {r_q[dfs_pkg::DIV_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

FILE: src/dfs_dp.sv
// Datapath: entry table, status flags, scan registers, divider and result registers.
module dfs_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dfs_pkg::t_cmd                     i_cmd,
    output dfs_pkg::t_stat                    o_stat,
    input  dfs_pkg::t_in                      i_in,
    input  logic                              i_cfg_we,
    input  logic [dfs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dfs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output dfs_pkg::t_out                     o_out,
    output logic                              o_out_valid,
    input  logic                              i_out_ready
);
    localparam int IW = dfs_pkg::IDX_W;

    typedef enum logic [2:0] {ST_NONE, ST_RETIRE, ST_DARK, ST_READY, ST_NOSLACK} t_st;

    dfs_pkg::t_rec mem [dfs_pkg::TABLE_DEPTH];
    dfs_pkg::t_rec r_rd;
    dfs_pkg::t_in  r_in;
    dfs_pkg::t_out r_res, r_out;
    logic          r_out_valid;

    logic [dfs_pkg::TABLE_DEPTH-1:0] r_doable, r_ready;
    logic [8:0]  r_active;
    logic [7:0]  r_ovh;
    logic [15:0] r_mgap;
    logic [11:0] r_idle;

    logic [IW-1:0]            r_idx, r_pick;
    logic                     r_pick_v, r_nready, r_short;
    logic [dfs_pkg::NL_W-1:0] r_nl_min;
    logic signed [21:0]       r_best;

    logic [IW:0]              n_eff;
    logic                     w_we;
    logic [IW-1:0]            w_addr;
    dfs_pkg::t_rec            w_data;

    // Load arithmetic.
    logic signed [17:0]       up_l;
    logic signed [6:0]        wm1;
    logic signed [23:0]       prod_l, slack_lw;
    logic                     want_ok;
    dfs_pkg::t_rec            load_rec;

    // Status pass arithmetic.
    logic signed [18:0]       d_rise, d_set, d_due;
    logic signed [17:0]       up_p;
    logic [dfs_pkg::NL_W-1:0] nl;
    logic [20:0]              prod_p;
    logic signed [23:0]       slack_w;
    t_st                      st;

    logic                     hit_a, hit_b;

    // Shortening.
    logic signed [5:0]        n_sh;
    logic [20:0]              mg_prod;
    logic                     sh_ok, div_done;
    logic [dfs_pkg::DIV_W-1:0] div_q;
    logic [15:0]              gap_sh;

    // Observation.
    logic [4:0]               done1;
    logic [17:0]              due_s;
    logic [16:0]              due;

    assign n_eff = (r_active > (IW+1)'(dfs_pkg::TABLE_DEPTH)) ?
                   (IW+1)'(dfs_pkg::TABLE_DEPTH) : r_active;

    always_comb begin
        up_l     = dfs_pkg::fwd_span(r_in.rise_time, r_in.set_time);
        wm1      = $signed({2'b00, r_in.repeats_wanted}) - 7'sd1;
        prod_l   = wm1 * $signed({1'b0, r_in.repeat_gap_s});
        slack_lw = 24'(up_l) - prod_l;
        want_ok  = (r_in.repeats_wanted >= 5'd1) &&
                   (r_in.repeats_wanted <= 5'(dfs_pkg::MAX_REPEATS));
        load_rec.done     = '0;
        load_rec.wanted   = r_in.repeats_wanted;
        load_rec.shutter  = r_in.open_shutter;
        load_rec.rise     = r_in.rise_time;
        load_rec.set      = r_in.set_time;
        load_rec.due      = r_in.first_time;
        load_rec.gap      = r_in.repeat_gap_s;
        load_rec.exposure = r_in.exposure_s;
        load_rec.up       = up_l;
        load_rec.slack    = r_in.open_shutter ? slack_lw[21:0] : 22'(up_l);
    end

    always_comb begin
        d_rise  = dfs_pkg::clk_diff(r_in.clock_now, r_rd.rise);
        d_set   = dfs_pkg::clk_diff(r_in.clock_now, r_rd.set);
        d_due   = dfs_pkg::clk_diff(r_in.clock_now, r_rd.due);
        up_p    = dfs_pkg::fwd_span(r_in.clock_now, r_rd.set);
        nl      = r_rd.wanted - r_rd.done;
        prod_p  = 21'(nl) * 21'(r_rd.gap);
        slack_w = 24'(up_p) - $signed({3'b000, prod_p});
        if (!r_doable[r_idx])              st = ST_NONE;
        else if (r_rd.done == r_rd.wanted) st = ST_RETIRE;
        else if (d_rise > 19'sd0)          st = ST_NONE;
        else if (d_set < 19'sd0)           st = ST_RETIRE;
        else if (d_due > 19'sd0)           st = ST_NONE;
        else if (!r_rd.shutter)            st = ST_DARK;
        else if (slack_w < 24'sd0)         st = ST_NOSLACK;
        else                               st = ST_READY;
    end

    assign hit_a = r_ready[r_idx] && (nl == r_nl_min) && (!r_pick_v || r_rd.slack < r_best);
    assign hit_b = r_doable[r_idx] && (!r_pick_v || r_rd.slack > r_best);

    assign n_sh    = $signed({1'b0, r_rd.wanted}) - $signed({1'b0, r_rd.done});
    assign mg_prod = 21'(r_mgap) * 21'(n_sh[4:0]);
    assign sh_ok   = (n_sh > 6'sd0) && ($signed(24'(r_rd.up)) > $signed({3'b000, mg_prod}));
    assign gap_sh  = (div_q > 17'd65535) ? 16'hFFFF : div_q[15:0];

    assign done1 = r_rd.done + 5'd1;
    assign due_s = {1'b0, r_in.clock_now} + {2'b00, r_rd.gap};
    assign due   = (due_s >= dfs_pkg::DAY_U) ? 17'(due_s - dfs_pkg::DAY_U) : due_s[16:0];

    dfs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    ((i_cmd.op == dfs_pkg::OP_SH_CHK) && sh_ok),
        .i_dividend (r_rd.up[dfs_pkg::DIV_W-1:0]),
        .i_divisor  (n_sh[dfs_pkg::NL_W-1:0]),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // Single table write port.
    always_comb begin
        w_we   = 1'b0;
        w_addr = r_idx;
        w_data = r_rd;
        case (i_cmd.op)
            dfs_pkg::OP_LOAD: begin
                w_we   = 1'b1;
                w_addr = r_in.entry_index[IW-1:0];
                w_data = load_rec;
            end
            dfs_pkg::OP_P1: begin
                w_we         = (st == ST_READY) || (st == ST_NOSLACK);
                w_data.up    = up_p;
                w_data.slack = slack_w[21:0];
            end
            dfs_pkg::OP_SH_WR: begin
                w_we         = 1'b1;
                w_data.gap   = gap_sh;
                w_data.slack = '0;
            end
            dfs_pkg::OP_OBS: begin
                w_we        = 1'b1;
                w_data.done = done1;
                w_data.due  = due;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_addr] <= w_data;
        if (i_cmd.op == dfs_pkg::OP_READ) r_rd <= mem[r_idx];
        if (i_cmd.take) r_in <= i_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= dfs_pkg::ACTIVE_RST;
            r_ovh    <= dfs_pkg::OVERHEAD_RST;
            r_mgap   <= dfs_pkg::MIN_GAP_RST;
            r_idle   <= dfs_pkg::IDLE_RST;
        end else if (i_cfg_we) begin
            case (dfs_pkg::t_cfg_idx'(i_cfg_idx))
                dfs_pkg::CFG_ACTIVE:    r_active <= i_cfg_data[8:0];
                dfs_pkg::CFG_OVERHEAD:  r_ovh    <= i_cfg_data[7:0];
                dfs_pkg::CFG_MIN_GAP:   r_mgap   <= i_cfg_data;
                dfs_pkg::CFG_IDLE_WAIT: r_idle   <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_doable    <= '0;
            r_ready     <= '0;
            r_out_valid <= 1'b0;
            r_pick_v    <= 1'b0;
            r_nready    <= 1'b0;
            r_short     <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (i_cmd.op)
                dfs_pkg::OP_LOAD: begin
                    r_doable[r_in.entry_index[IW-1:0]] <= r_in.can_do && want_ok;
                    r_ready[r_in.entry_index[IW-1:0]]  <= 1'b0;
                    r_res <= '0;
                end
                dfs_pkg::OP_P1_START: begin
                    r_idx    <= '0;
                    r_nready <= 1'b0;
                    r_nl_min <= dfs_pkg::NL_INIT;
                    r_pick_v <= 1'b0;
                    r_short  <= 1'b0;
                end
                dfs_pkg::OP_P1: begin
                    r_ready[r_idx] <= (st == ST_DARK) || (st == ST_READY);
                    if (st == ST_RETIRE) r_doable[r_idx] <= 1'b0;
                    if (st == ST_DARK) begin
                        r_pick   <= r_idx;
                        r_pick_v <= 1'b1;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (st == ST_READY) begin
                        r_nready <= 1'b1;
                        if (nl < r_nl_min) r_nl_min <= nl;
                    end
                end
                dfs_pkg::OP_P2_START: begin
                    r_idx    <= '0;
                    r_pick_v <= 1'b0;
                end
                dfs_pkg::OP_P2: begin
                    if (r_nready ? hit_a : hit_b) begin
                        r_pick   <= r_idx;
                        r_pick_v <= 1'b1;
                        r_best   <= r_rd.slack;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                dfs_pkg::OP_GO_PICK: r_idx <= r_pick;
                dfs_pkg::OP_SH_CHK: begin
                    if (!sh_ok) r_doable[r_idx] <= 1'b0;
                end
                dfs_pkg::OP_SH_WR: r_short <= 1'b1;
                dfs_pkg::OP_OBS: begin
                    r_res.chosen        <= 1'b1;
                    r_res.chosen_index  <= 8'(r_idx);
                    r_res.duration_s    <= 12'({1'b0, r_rd.exposure} + {3'b000, r_ovh});
                    r_res.repeats_done  <= done1;
                    r_res.next_due      <= due;
                    r_res.was_shortened <= r_short;
                end
                dfs_pkg::OP_IDLE: begin
                    r_res            <= '0;
                    r_res.duration_s <= r_idle;
                end
                dfs_pkg::OP_EMIT: begin
                    r_out       <= r_res;
                    r_out_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.is_load  = (r_in.cmd == dfs_pkg::CMD_LOAD);
        o_stat.empty    = (n_eff == '0);
        o_stat.last     = ({1'b0, r_idx} == n_eff - 1'b1);
        o_stat.dark     = (st == ST_DARK);
        o_stat.nready   = r_nready;
        o_stat.pick_v   = r_pick_v;
        o_stat.sh_ok    = sh_ok;
        o_stat.div_done = div_done;
        o_stat.out_free = !r_out_valid;
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;
endmodule

FILE: src/dfs_ctrl.sv
// Controller: sequences loads, the status pass, the pick pass, shortening and results.
module dfs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dfs_pkg::t_stat i_stat,
    output dfs_pkg::t_cmd  o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_P1_RD, S_P1_EV, S_P2_INIT, S_P2_RD, S_P2_EV, S_P2_END,
        S_SH_RD, S_SH_CHK, S_SH_DIV, S_SH_WR, S_OB_RD, S_OB_EV, S_IDLE_RES, S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd.take = i_in_valid && r_in_ready;
        o_cmd.op   = dfs_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.take) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (i_stat.is_load) begin
                    o_cmd.op = dfs_pkg::OP_LOAD;
                    n_state  = S_EMIT;
                end else begin
                    o_cmd.op = dfs_pkg::OP_P1_START;
                    n_state  = i_stat.empty ? S_IDLE_RES : S_P1_RD;
                end
            end
            S_P1_RD: begin
                o_cmd.op = dfs_pkg::OP_READ;
                n_state  = S_P1_EV;
            end
            S_P1_EV: begin
                o_cmd.op = dfs_pkg::OP_P1;
                if (i_stat.dark)      n_state = S_OB_RD;
                else if (i_stat.last) n_state = S_P2_INIT;
                else                  n_state = S_P1_RD;
            end
            S_P2_INIT: begin
                o_cmd.op = dfs_pkg::OP_P2_START;
                n_state  = S_P2_RD;
            end
            S_P2_RD: begin
                o_cmd.op = dfs_pkg::OP_READ;
                n_state  = S_P2_EV;
            end
            S_P2_EV: begin
                o_cmd.op = dfs_pkg::OP_P2;
                n_state  = i_stat.last ? S_P2_END : S_P2_RD;
            end
            S_P2_END: begin
                o_cmd.op = dfs_pkg::OP_GO_PICK;
                if (!i_stat.pick_v)    n_state = S_IDLE_RES;
                else if (i_stat.nready) n_state = S_OB_RD;
                else                   n_state = S_SH_RD;
            end
            S_SH_RD: begin
                o_cmd.op = dfs_pkg::OP_READ;
                n_state  = S_SH_CHK;
            end
            S_SH_CHK: begin
                o_cmd.op = dfs_pkg::OP_SH_CHK;
                n_state  = i_stat.sh_ok ? S_SH_DIV : S_IDLE_RES;
            end
            S_SH_DIV: begin
                if (i_stat.div_done) n_state = S_SH_WR;
            end
            S_SH_WR: begin
                o_cmd.op = dfs_pkg::OP_SH_WR;
                n_state  = S_OB_RD;
            end
            S_OB_RD: begin
                o_cmd.op = dfs_pkg::OP_READ;
                n_state  = S_OB_EV;
            end
            S_OB_EV: begin
                o_cmd.op = dfs_pkg::OP_OBS;
                n_state  = S_EMIT;
            end
            S_IDLE_RES: begin
                o_cmd.op = dfs_pkg::OP_IDLE;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = dfs_pkg::OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;
endmodule

FILE: src/deadline_field_selector_core.sv
// Top level of the deadline field selector: table of observation entries and its scheduler.
// A load beat writes one of 256 table entries and returns an all-zero result beat. A select
// beat at a clock time walks entries 0 to n-1 (n is active_entries, capped at 256) once to
// update their status, stops early on the first ready dark frame, and otherwise walks them a
// second time to pick the ready sky entry with the fewest repeats left and then the least
// slack, or, with none ready, the doable entry with the most slack, whose repeat interval is
// then shortened by a serial divider if the minimum gap allows it. The table is one memory
// with a single read port, and every walk step is a read, then an evaluate and write back.
// The block takes one beat at a time; a finished result waits in the output register,
// and the next input beat is accepted as soon as that result has been moved there.
// Configuration writes are taken at any time but should only be made while the block
// is idle.
module deadline_field_selector_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    dfs_in_if.sink                             i_in,
    dfs_out_if.source                          o_out,
    input  logic                               i_cfg_we,
    input  logic [dfs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dfs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    dfs_pkg::t_cmd  cmd;
    dfs_pkg::t_stat stat;
    dfs_pkg::t_in   in_beat;
    dfs_pkg::t_out  out_beat;
    logic           out_valid;

    // Gather the input payload into one word for the datapath.
    always_comb begin
        in_beat.cmd            = i_in.cmd;
        in_beat.entry_index    = i_in.entry_index;
        in_beat.clock_now      = i_in.clock_now;
        in_beat.open_shutter   = i_in.open_shutter;
        in_beat.rise_time      = i_in.rise_time;
        in_beat.set_time       = i_in.set_time;
        in_beat.first_time     = i_in.first_time;
        in_beat.repeat_gap_s   = i_in.repeat_gap_s;
        in_beat.exposure_s     = i_in.exposure_s;
        in_beat.repeats_wanted = i_in.repeats_wanted;
        in_beat.can_do         = i_in.can_do;
    end

    dfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dfs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in        (in_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out       (out_beat),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready)
    );

    // The result register drives the output channel directly.
    assign o_out.valid         = out_valid;
    assign o_out.chosen        = out_beat.chosen;
    assign o_out.chosen_index  = out_beat.chosen_index;
    assign o_out.duration_s    = out_beat.duration_s;
    assign o_out.repeats_done  = out_beat.repeats_done;
    assign o_out.next_due      = out_beat.next_due;
    assign o_out.was_shortened = out_beat.was_shortened;
endmodule

FILE: src/dfs_chk.sv
// Port-level checks of the deadline field selector and their binding.
module dfs_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_chosen,
    input logic [7:0]  i_chosen_index,
    input logic [4:0]  i_repeats_done,
    input logic [16:0] i_next_due,
    input logic        i_was_shortened
);
    // A result beat stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped before it was taken");

    // The block works on one beat at a time.
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted again right after an accept");

    // Only an observed entry can come from the shortening fallback.
    a_short_chosen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_was_shortened |-> i_chosen)
        else $error("shortened flag without a chosen entry");

    // With nothing observed, the entry fields read zero.
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_chosen |->
            (i_chosen_index == 8'd0) && (i_repeats_done == 5'd0) && (i_next_due == 17'd0))
        else $error("entry fields set on a result without an observation");
endmodule

bind deadline_field_selector_core dfs_chk u_dfs_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_chosen        (o_out.chosen),
    .i_chosen_index  (o_out.chosen_index),
    .i_repeats_done  (o_out.repeats_done),
    .i_next_due      (o_out.next_due),
    .i_was_shortened (o_out.was_shortened)
);

FILE: verif/dfs_checker.sv
// Checker: watches the channels of the deadline field selector, predicts each result beat and compares it.
`timescale 1ns / 100ps
module dfs_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dfs_in_if                              in_ch,
    dfs_out_if                             out_ch,
    input  logic                           i_cfg_we,
    input  logic [dfs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dfs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import dfs_pkg::*;

    localparam int DAY = 86400;
    localparam int HALF = 43200;
    localparam int ST_LATE = -1;
    localparam int ST_NONE = 0;
    localparam int ST_READY = 1;
    localparam int ST_DARK = 2;

    int unsigned n_active, overhead, min_gap, idle_wait;
    bit doable[TABLE_DEPTH];
    bit ready_now[TABLE_DEPTH];
    bit shut[TABLE_DEPTH];
    int done_c[TABLE_DEPTH], want_c[TABLE_DEPTH];
    int rise_s[TABLE_DEPTH], set_s[TABLE_DEPTH], due_s[TABLE_DEPTH], gap_s[TABLE_DEPTH];
    int expo_s[TABLE_DEPTH], up_s[TABLE_DEPTH], slack_s[TABLE_DEPTH];
    t_out outcome_q[$];

    function automatic int day_delta(int a, int b);
        int d;
        d = b - a;
        if (d > HALF) d -= DAY;
        if (d < -HALF) d += DAY;
        return d;
    endfunction

    // Updates one entry's status at time now and tells whether it can be observed.
    function automatic int entry_state(int i, int now);
        int up;
        if (!doable[i]) return ST_NONE;
        if (done_c[i] == want_c[i]) begin
            doable[i] = 0;
            return ST_NONE;
        end
        if (day_delta(now, rise_s[i]) > 0) return ST_NONE;
        if (day_delta(now, set_s[i]) < 0) begin
            doable[i] = 0;
            return ST_NONE;
        end
        if (day_delta(now, due_s[i]) > 0) return ST_NONE;
        if (!shut[i]) return ST_DARK;
        up = set_s[i] - now;
        if (up < 0) up += DAY;
        up_s[i] = up;
        slack_s[i] = up - (want_c[i] - done_c[i]) * gap_s[i];
        return (slack_s[i] < 0) ? ST_LATE : ST_READY;
    endfunction

    function automatic t_out schedule_beat(t_in x);
        t_out r;
        int idx, up, now, n, i, st, pick, nready, nl, nl_min, best, best_slack, due, left;
        bit shortened;
        longint g;
        r = '0;
        if (x.cmd == CMD_LOAD) begin
            idx = x.entry_index;
            shut[idx] = x.open_shutter;
            rise_s[idx] = x.rise_time;
            set_s[idx] = x.set_time;
            due_s[idx] = x.first_time;
            gap_s[idx] = x.repeat_gap_s;
            expo_s[idx] = x.exposure_s;
            want_c[idx] = x.repeats_wanted;
            done_c[idx] = 0;
            ready_now[idx] = 0;
            doable[idx] = x.can_do;
            if (x.repeats_wanted < 1 || x.repeats_wanted > MAX_REPEATS) doable[idx] = 0;
            up = set_s[idx] - rise_s[idx];
            if (up < 0) up += DAY;
            up_s[idx] = up;
            slack_s[idx] = shut[idx] ? up - (want_c[idx] - 1) * gap_s[idx] : up;
            return r;
        end
        now = x.clock_now;
        n = (n_active > TABLE_DEPTH) ? TABLE_DEPTH : n_active;
        pick = -1;
        nready = 0;
        nl_min = 1000;
        best_slack = 0;
        shortened = 0;
        for (i = 0; i < n; i++) begin
            ready_now[i] = 0;
            st = entry_state(i, now);
            if (st == ST_DARK) begin
                ready_now[i] = 1;
                pick = i;
                break;
            end
            if (st == ST_READY) begin
                ready_now[i] = 1;
                nready++;
                nl = want_c[i] - done_c[i];
                if (nl < nl_min) nl_min = nl;
            end
        end
        if (pick < 0 && nready > 0) begin
            for (i = 0; i < n; i++) begin
                nl = want_c[i] - done_c[i];
                if (ready_now[i] && nl == nl_min && (pick < 0 || slack_s[i] < best_slack)) begin
                    pick = i;
                    best_slack = slack_s[i];
                end
            end
        end else if (pick < 0) begin
            best = -1;
            for (i = 0; i < n; i++) begin
                if (doable[i] && (best < 0 || slack_s[i] > best_slack)) begin
                    best = i;
                    best_slack = slack_s[i];
                end
            end
            if (best >= 0) begin
                // Stretch the remaining repeats over the time left, or give up on the entry.
                left = want_c[best] - done_c[best];
                if (left <= 0 || longint'(up_s[best]) <= longint'(min_gap) * left) begin
                    doable[best] = 0;
                end else begin
                    g = up_s[best] / left;
                    if (g > 65535) g = 65535;
                    gap_s[best] = int'(g);
                    slack_s[best] = 0;
                    pick = best;
                    shortened = 1;
                end
            end
        end
        if (pick < 0) begin
            r.duration_s = idle_wait[11:0];
            return r;
        end
        done_c[pick] = (done_c[pick] + 1) & 31;
        due = now + gap_s[pick];
        if (due >= DAY) due -= DAY;
        due_s[pick] = due;
        r.chosen = 1'b1;
        r.chosen_index = pick[7:0];
        r.duration_s = 12'(expo_s[pick] + overhead);
        r.repeats_done = done_c[pick][4:0];
        r.next_due = due[16:0];
        r.was_shortened = shortened;
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_in beat;
        t_out want;
        if (!i_rst_n) begin
            n_active = ACTIVE_RST;
            overhead = OVERHEAD_RST;
            min_gap = MIN_GAP_RST;
            idle_wait = IDLE_RST;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                doable[i] = 0;
                ready_now[i] = 0;
            end
            outcome_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ACTIVE:    n_active = i_cfg_data[8:0];
                    CFG_OVERHEAD:  overhead = i_cfg_data[7:0];
                    CFG_MIN_GAP:   min_gap = i_cfg_data;
                    CFG_IDLE_WAIT: idle_wait = i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %p", $time,
                             {out_ch.chosen, out_ch.chosen_index, out_ch.duration_s});
                    o_fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("chosen", want.chosen, out_ch.chosen);
                    check_field("chosen_index", want.chosen_index, out_ch.chosen_index);
                    check_field("duration_s", want.duration_s, out_ch.duration_s);
                    check_field("repeats_done", want.repeats_done, out_ch.repeats_done);
                    check_field("next_due", want.next_due, out_ch.next_due);
                    check_field("was_shortened", want.was_shortened, out_ch.was_shortened);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                beat.cmd = in_ch.cmd;
                beat.entry_index = in_ch.entry_index;
                beat.clock_now = in_ch.clock_now;
                beat.open_shutter = in_ch.open_shutter;
                beat.rise_time = in_ch.rise_time;
                beat.set_time = in_ch.set_time;
                beat.first_time = in_ch.first_time;
                beat.repeat_gap_s = in_ch.repeat_gap_s;
                beat.exposure_s = in_ch.exposure_s;
                beat.repeats_wanted = in_ch.repeats_wanted;
                beat.can_do = in_ch.can_do;
                outcome_q.push_back(schedule_beat(beat));
            end
        end
        o_pending <= outcome_q.size();
    end

    initial o_fail_count = 0;
endmodule

FILE: verif/testbench.sv
// Testbench top: clock, reset, stimulus and verdict for the deadline field selector.
`timescale 1ns / 100ps
module testbench;
    import dfs_pkg::*;

    localparam int DAY = 86400;
    localparam int ITEM_TARGET = 700;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int fail_count;
    int pending;
    int beats_sent = 0;
    bit quiet = 0;       // Set for the last part of the run, where neither side idles.
    bit hold_req = 0;    // Asks the receiver for one long hold-off.

    dfs_in_if in_ch();
    dfs_out_if out_ch();

    deadline_field_selector_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    dfs_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int wrap_day(int t);
        return ((t % DAY) + DAY) % DAY;
    endfunction

    // Sends one beat, with an optional random gap in front of it, and waits for acceptance.
    // Valid is left high afterwards so that back-to-back beats carry no bubble.
    task automatic send_beat(t_in b);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= b.cmd;
        in_ch.entry_index <= b.entry_index;
        in_ch.clock_now <= b.clock_now;
        in_ch.open_shutter <= b.open_shutter;
        in_ch.rise_time <= b.rise_time;
        in_ch.set_time <= b.set_time;
        in_ch.first_time <= b.first_time;
        in_ch.repeat_gap_s <= b.repeat_gap_s;
        in_ch.exposure_s <= b.exposure_s;
        in_ch.repeats_wanted <= b.repeats_wanted;
        in_ch.can_do <= b.can_do;
        do @(posedge i_clk); while (!in_ch.ready);
        beats_sent++;
        if (beats_sent == 300) hold_req = 1;
        if (beats_sent > ITEM_TARGET - 100) quiet = 1;
    endtask

    task automatic load_entry(int idx, bit sky, int rise, int set_t, int first, int gap,
                              int expo, int want, bit doable);
        t_in b;
        b = '0;
        b.cmd = CMD_LOAD;
        b.entry_index = idx[7:0];
        b.clock_now = 17'($urandom_range(0, DAY - 1));   // Ignored by a load.
        b.open_shutter = sky;
        b.rise_time = rise[16:0];
        b.set_time = set_t[16:0];
        b.first_time = first[16:0];
        b.repeat_gap_s = gap[15:0];
        b.exposure_s = expo[9:0];
        b.repeats_wanted = want[4:0];
        b.can_do = doable;
        send_beat(b);
    endtask

    task automatic select_at(int now);
        t_in b;
        b = t_in'($urandom());
        b.cmd = CMD_SELECT;
        b.clock_now = now[16:0];
        send_beat(b);
    endtask

    // Registers change only once the block has drained every result.
    task automatic set_config(int active, int ovh, int min_gap, int idle);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_ACTIVE;
        i_cfg_data <= active[15:0];
        @(posedge i_clk);
        i_cfg_idx <= CFG_OVERHEAD;
        i_cfg_data <= ovh[15:0];
        @(posedge i_clk);
        i_cfg_idx <= CFG_MIN_GAP;
        i_cfg_data <= min_gap[15:0];
        @(posedge i_clk);
        i_cfg_idx <= CFG_IDLE_WAIT;
        i_cfg_data <= idle[15:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // A plausible entry around clock time base: up now or soon, with a modest plan.
    task automatic load_plausible(int idx, int base);
        int rise, set_t, want;
        rise = wrap_day(base - int'($urandom_range(0, 3000)) + int'($urandom_range(0, 600)));
        set_t = wrap_day(base + int'($urandom_range(2000, 30000)));
        want = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_REPEATS)
                                            : $urandom_range(1, 5);
        load_entry(idx, $urandom_range(0, 7) != 0, rise, set_t,
                   wrap_day(base + int'($urandom_range(0, 900)) - 300),
                   $urandom_range(0, 7000), $urandom_range(0, 1000), want,
                   $urandom_range(0, 15) != 0);
    endtask

    // Anything the fields allow, including repeat counts outside the legal range.
    task automatic load_noise();
        load_entry($urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, DAY - 1),
                   $urandom_range(0, DAY - 1), $urandom_range(0, DAY - 1),
                   $urandom_range(0, 43200), $urandom_range(0, 1000),
                   $urandom_range(0, 31), $urandom_range(0, 1));
    endtask

    // Receiver: random stalls, one long hold-off on request, none near the end.
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    initial begin
        int base, n, phase;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_LOAD;
        in_ch.entry_index = '0;
        in_ch.clock_now = '0;
        in_ch.open_shutter = 1'b0;
        in_ch.rise_time = '0;
        in_ch.set_time = '0;
        in_ch.first_time = '0;
        in_ch.repeat_gap_s = '0;
        in_ch.exposure_s = '0;
        in_ch.repeats_wanted = '0;
        in_ch.can_do = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. With no active entries a select only reports the idle wait.
        select_at(0);
        select_at(DAY - 1);
        load_entry(255, 1, DAY - 1, DAY - 1, DAY - 1, 43200, 1000, MAX_REPEATS, 1);
        load_entry(0, 0, 0, 0, 0, 0, 0, 1, 0);
        set_config(4, 255, 0, 4095);
        // A dark frame due now is taken first.
        load_entry(0, 0, 100, 2000, 100, 0, 1000, 2, 1);
        // Two sky entries with equal repeats left, differing in slack.
        load_entry(1, 1, 0, 5000, 0, 1000, 10, 2, 1);
        load_entry(2, 1, 0, 4000, 0, 1000, 20, 2, 1);
        // Window across midnight, not yet due, so only shortening can pick it.
        load_entry(3, 1, 86000, 3000, 2000, 40000, 0, 3, 1);
        select_at(500);
        select_at(500);
        select_at(600);
        select_at(600);
        select_at(86399);
        // Bad repeat counts leave the entry retired.
        load_entry(1, 1, 0, 5000, 0, 100, 5, 0, 1);
        load_entry(2, 1, 0, 5000, 0, 100, 5, 31, 1);
        select_at(700);
        // The minimum gap forbids shortening; an entry whose window passed is retired.
        set_config(4, 0, 65535, 0);
        load_entry(3, 1, 86000, 3000, 2000, 40000, 0, 3, 1);
        load_entry(0, 1, 100, 200, 100, 10, 0, 2, 1);
        select_at(500);
        select_at(86100);

        // Random phases of plausible plans, with the odd stray load.
        phase = 0;
        while (beats_sent < ITEM_TARGET) begin
            case (phase % 6)
                0: n = 0;
                3: n = (phase == 3) ? 256 : $urandom_range(1, 12);
                default: n = $urandom_range(1, 12);
            endcase
            set_config(n, (phase % 4 == 1) ? 255 : $urandom_range(0, 255),
                       (phase % 5 == 2) ? 65535 : $urandom_range(0, 2500),
                       (phase % 4 == 2) ? 4095 : $urandom_range(0, 4095));
            base = $urandom_range(0, DAY - 1);
            for (int i = 0; i < ((n == 0) ? 3 : n); i++) load_plausible(i, base);
            repeat ($urandom_range(10, 30)) begin
                if ($urandom_range(0, 9) == 0) load_noise();
                else select_at(base);
                base = wrap_day(base + int'($urandom_range(0, 1500)));
            end
            phase++;
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Far beyond the slowest correct run; reaching it means the block hung.
    initial begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end
endmodule
